// ===== rtl/core/upd_pkg.sv =====
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } decode_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'd97) && (b <= 8'd102)) || ((b >= 8'd65) && (b <= 8'd70));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (is_digit(b)) begin
      v = b - 8'd48;
    end else if ((b >= 8'd97) && (b <= 8'd102)) begin
      v = b - 8'd87;
    end else if ((b >= 8'd65) && (b <= 8'd70)) begin
      v = b - 8'd55;
    end
    return v[3:0];
  endfunction

  function automatic logic is_safe(input logic [7:0] v);
    logic s;
    s = is_digit(v) || ((v >= 8'd97) && (v <= 8'd122)) || ((v >= 8'd65) && (v <= 8'd90));
    s = s || (v == 8'h21) || (v == 8'h24) || ((v >= 8'h26) && (v <= 8'h2F));
    s = s || (v == 8'h3A) || (v == 8'h3B) || (v == 8'h3D) || (v == 8'h3F);
    s = s || (v == 8'h40) || (v == 8'h5F);
    return s;
  endfunction

endpackage

// ===== rtl/core/upd_decoder.sv =====
`timescale 1ns / 1ps

module upd_decoder import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       commit,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output decode_t    dec
);

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic       b_hex;
  logic       b_pct;
  logic [7:0] plain_byte;
  logic [7:0] pair_val;

  always_comb begin
    b_hex      = is_hex(in_byte);
    b_pct      = (in_byte == CHAR_PCT);
    plain_byte = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;
    pair_val   = {hex_val(held_r), hex_val(in_byte)};

    phase_nxt = PH_PLAIN;
    held_nxt  = held_r;
    dec.cnt   = 2'd0;
    dec.b0    = CHAR_PCT;
    dec.b1    = CHAR_PCT;
    dec.b2    = CHAR_PCT;
    dec.last  = in_last;

    case (phase_r)
      PH_PCT: begin
        if (b_hex) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIGIT;
          if (in_last) begin
            dec.b1  = in_byte;
            dec.cnt = 2'd2;
          end
        end else if (b_pct) begin
          phase_nxt = PH_PCT;
          dec.cnt   = in_last ? 2'd2 : 2'd1;
        end else begin
          dec.b1  = plain_byte;
          dec.cnt = 2'd2;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          if (!is_safe(pair_val)) begin
            dec.b0  = pair_val;
            dec.cnt = 2'd1;
          end else begin
            dec.b1  = held_r;
            dec.b2  = in_byte;
            dec.cnt = 2'd3;
          end
        end else if (b_pct) begin
          phase_nxt = PH_PCT;
          dec.b1    = held_r;
          dec.cnt   = in_last ? 2'd3 : 2'd2;
        end else begin
          dec.b1  = held_r;
          dec.b2  = plain_byte;
          dec.cnt = 2'd3;
        end
      end
      default: begin
        if (b_pct) begin
          phase_nxt = PH_PCT;
          dec.cnt   = in_last ? 2'd1 : 2'd0;
        end else begin
          dec.b0  = plain_byte;
          dec.cnt = 2'd1;
        end
      end
    endcase

    if (in_last) begin
      phase_nxt = PH_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= 8'd0;
    end else if (commit) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/upd_out_buf.sv =====
`timescale 1ns / 1ps

module upd_out_buf import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  decode_t    grp,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] q0_r, q0_nxt;
  logic [7:0] q1_r, q1_nxt;
  logic [7:0] q2_r, q2_nxt;
  logic       last_r, last_nxt;
  logic       take;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q0_r;
  assign out_tlast  = last_r && (cnt_r == 2'd1);
  assign take       = out_tvalid && out_tready;
  assign can_load   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_comb begin
    cnt_nxt  = cnt_r;
    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    q2_nxt   = q2_r;
    last_nxt = last_r;
    if (load) begin
      cnt_nxt  = grp.cnt;
      q0_nxt   = grp.b0;
      q1_nxt   = grp.b1;
      q2_nxt   = grp.b2;
      last_nxt = grp.last;
    end else if (take) begin
      cnt_nxt = cnt_r - 2'd1;
      q0_nxt  = q1_r;
      q1_nxt  = q2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r   <= q0_nxt;
    q1_r   <= q1_nxt;
    q2_r   <= q2_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/core/url_percent_decoder_top.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata           tlast     notes
// in_       in   [7:0] in_byte   in_last   one encoded byte per request
// out_      out  [7:0] out_byte  out_last  zero to three decoded bytes per input byte
//
// an input byte is decoded in the cycle after it is taken into the input register
// one input byte per cycle while each yields at most one output byte and out_tready is high
// an escape that passes through as three bytes holds the input until the result buffer is down to its last byte
// rst_n clears the escape phase and empties the input register and the result buffer
// out_tready low stalls the result buffer, then the input register, then in_tready

module url_percent_decoder_top import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       in_take;
  logic       commit;
  logic       can_load;
  logic       load;
  decode_t    dec;

  assign commit    = in_valid_r && ((dec.cnt == 2'd0) || can_load);
  assign load      = commit && (dec.cnt != 2'd0);
  assign in_tready = !in_valid_r || commit;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (commit) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  upd_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .dec     (dec)
  );

  upd_out_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .grp        (dec),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // every string end produces at least one byte
  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && in_last_r) |-> (dec.cnt != 2'd0))
    else $error("string end committed with no output byte");

  // a loaded group shows up on the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("decoded group lost after load");

  // an accepted byte is held in the input register
  a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted input byte dropped");

  // a stalled tail byte keeps its end marker
  a_tlast_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && !out_tready) |=> (out_tvalid && out_tlast))
    else $error("end marker lost under stall");

endmodule
